// ===== src/lcg_fisher_yates_deck_shuffle_core_defines.svh =====
`ifndef LCG_FISHER_YATES_DECK_SHUFFLE_CORE_DEFINES_SVH
`define LCG_FISHER_YATES_DECK_SHUFFLE_CORE_DEFINES_SVH

// Assertion wrappers: full checks in simulation, empty when SYNTH is set.
`ifndef SYNTH

`define LFYDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define LFYDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LFYDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LFYDS_ASSERT(lbl, clk, rst_n, prop, msg)

`define LFYDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define LFYDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/lfyds_pkg.sv =====
package lfyds_pkg;

    localparam int DECK_SIZE = 52;
    localparam int CARD_W    = $clog2(DECK_SIZE);
    localparam int SUIT_LEN  = 13;

    localparam int SEED_W     = 32;
    localparam int POS_W      = 6;
    localparam int RANK_W     = 4;
    localparam int SUIT_W     = 2;
    localparam int OUT_DATA_W = 16;
    localparam int PAD_W      = OUT_DATA_W - POS_W - RANK_W - SUIT_W;

    localparam int GEN_W     = 64;
    localparam int MUL_W     = 32;
    localparam int FRAC_LSB  = 21;
    localparam int FRAC_W    = 31;
    localparam int DRAW_LSB  = FRAC_W;

    localparam logic [MUL_W-1:0] LCG_MUL_LO = 32'h4C957F2D;
    localparam logic [MUL_W-1:0] LCG_MUL_HI = 32'h5851F42D;

    localparam logic [CARD_W-1:0] LAST_CARD = CARD_W'(DECK_SIZE - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_GEN,
        ST_TAIL,
        ST_PRIME,
        ST_EMIT
    } t_state;

    // Sub-steps of one generator draw; the swap tail reuses the first three.
    typedef enum logic [2:0] {
        PH_MUL_LL,
        PH_MUL_HL,
        PH_MUL_LH,
        PH_SUM,
        PH_DRAW
    } t_phase;

    typedef struct packed {
        logic              rd_en;
        logic [CARD_W-1:0] rd_a_addr;
        logic [CARD_W-1:0] rd_b_addr;
        logic              wr_en;
        logic [CARD_W-1:0] wr_addr;
        logic [CARD_W-1:0] wr_data;
    } t_deck_ctl;

    function automatic logic [SUIT_W-1:0] card_suit(input logic [CARD_W-1:0] card);
        int c;
        c = int'(card);
        if (c >= 3 * SUIT_LEN) begin
            return SUIT_W'(3);
        end else if (c >= 2 * SUIT_LEN) begin
            return SUIT_W'(2);
        end else if (c >= SUIT_LEN) begin
            return SUIT_W'(1);
        end
        return SUIT_W'(0);
    endfunction

    function automatic logic [RANK_W-1:0] card_rank(input logic [CARD_W-1:0] card);
        int c;
        int s;
        c = int'(card);
        s = int'(card_suit(card));
        return RANK_W'(c - SUIT_LEN * s + 1);
    endfunction

endpackage

// ===== src/lcg_fisher_yates_deck_shuffle_core.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[31:0] seed (signed)
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata position[5:0], rank[9:6],
//                                              suit[11:10], zero[15:12]; tlast
//
// One seed yields DECK_SIZE card beats. Each draw steps through its phases on
// the shared registered 32x32 multiplier; the deck fill runs one card a cycle
// through the single deck write port. Ready is high only between deals, and
// output stalls hold the deal in its emit phase until the beat is taken.
// Reset (synchronous, active low) returns the sequencer to idle.
`include "lcg_fisher_yates_deck_shuffle_core_defines.svh"

module lcg_fisher_yates_deck_shuffle_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lfyds_pkg::SEED_W-1:0]     s_axis_tdata,   // seed
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lfyds_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // position, rank, suit, pad
    output logic                             m_axis_tlast
);
    import lfyds_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_first;
    logic                n_first;
    logic                r_wr1;
    logic                r_wr2;
    logic [CARD_W-1:0]   r_n;
    logic [CARD_W-1:0]   n_n;
    logic [CARD_W-1:0]   r_fill;
    logic [CARD_W-1:0]   n_fill;
    logic [CARD_W-1:0]   r_idx;
    logic [CARD_W-1:0]   n_idx;
    logic [CARD_W-1:0]   r_swn;
    logic [CARD_W-1:0]   n_swn;
    logic [CARD_W-1:0]   r_j;
    logic [CARD_W-1:0]   n_j;
    logic [GEN_W-1:0]    r_gen;
    logic [GEN_W-1:0]    n_gen;
    logic [GEN_W-1:0]    r_lo64;
    logic [GEN_W-1:0]    n_lo64;
    logic [MUL_W-1:0]    r_cross;
    logic [MUL_W-1:0]    n_cross;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*MUL_W-1:0]  prod;
    logic [CARD_W-1:0]   draw_j;
    logic                swap_rd;
    logic                fill_we;
    logic [CARD_W-1:0]   emit_idx;
    logic                in_acc;
    logic                out_acc;
    t_deck_ctl           deck_ctl;
    logic [CARD_W-1:0]   rd_a;
    logic [CARD_W-1:0]   rd_b;

    lfyds_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    lfyds_deck u_deck (
        .i_clk  (i_clk),
        .i_ctl  (deck_ctl),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign draw_j  = prod[DRAW_LSB +: CARD_W];

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_first  = r_first;
        n_n      = r_n;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_swn    = r_swn;
        n_j      = r_j;
        n_gen    = r_gen;
        n_lo64   = r_lo64;
        n_cross  = r_cross;
        mul_a    = r_gen[MUL_W-1:0];
        mul_b    = LCG_MUL_LO;
        swap_rd  = 1'b0;
        fill_we  = 1'b0;
        emit_idx = r_idx;

        deck_ctl.rd_en     = 1'b0;
        deck_ctl.rd_a_addr = r_n;
        deck_ctl.rd_b_addr = r_j;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_gen   = {{(GEN_W-SEED_W){s_axis_tdata[SEED_W-1]}}, s_axis_tdata};
                    n_fill  = '0;
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                fill_we = 1'b1;
                if (r_fill == LAST_CARD) begin
                    n_state = ST_GEN;
                    n_phase = PH_MUL_LL;
                    n_first = 1'b1;
                    n_n     = LAST_CARD;
                end else begin
                    n_fill = r_fill + 1'b1;
                end
            end
            ST_GEN: begin
                unique case (r_phase)
                    PH_MUL_LL: begin
                        // prod still holds the previous draw: start its swap
                        swap_rd = !r_first;
                        n_phase = PH_MUL_HL;
                    end
                    PH_MUL_HL: begin
                        mul_a   = r_gen[GEN_W-1:MUL_W];
                        n_lo64  = prod;
                        n_phase = PH_MUL_LH;
                    end
                    PH_MUL_LH: begin
                        mul_b   = LCG_MUL_HI;
                        n_cross = prod[MUL_W-1:0];
                        n_phase = PH_SUM;
                    end
                    PH_SUM: begin
                        n_gen   = r_lo64 + {r_cross + prod[MUL_W-1:0], {MUL_W{1'b0}}}
                                  + GEN_W'(1);
                        n_phase = PH_DRAW;
                    end
                    PH_DRAW: begin
                        mul_a   = MUL_W'(r_gen[FRAC_LSB +: FRAC_W]);
                        mul_b   = MUL_W'(r_n) + MUL_W'(1);
                        n_phase = PH_MUL_LL;
                        n_first = 1'b0;
                        if (r_n == CARD_W'(1)) begin
                            n_state = ST_TAIL;
                        end
                    end
                    default: begin
                        n_phase = PH_MUL_LL;
                    end
                endcase
            end
            ST_TAIL: begin
                // last swap: read, then two writes
                unique case (r_phase)
                    PH_MUL_LL: begin
                        swap_rd = 1'b1;
                        n_phase = PH_MUL_HL;
                    end
                    PH_MUL_HL: begin
                        n_phase = PH_MUL_LH;
                    end
                    PH_MUL_LH: begin
                        n_phase = PH_MUL_LL;
                        n_state = ST_PRIME;
                    end
                    default: begin
                        n_phase = PH_MUL_LL;
                        n_state = ST_PRIME;
                    end
                endcase
            end
            ST_PRIME: begin
                emit_idx           = '0;
                n_idx              = '0;
                deck_ctl.rd_en     = 1'b1;
                deck_ctl.rd_a_addr = LAST_CARD - emit_idx;
                n_state            = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (r_idx == LAST_CARD) begin
                        n_state = ST_IDLE;
                    end else begin
                        emit_idx = r_idx + 1'b1;
                    end
                end
                // read ahead so the next card is ready in the cycle after a beat
                n_idx              = emit_idx;
                deck_ctl.rd_en     = 1'b1;
                deck_ctl.rd_a_addr = LAST_CARD - emit_idx;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (swap_rd) begin
            deck_ctl.rd_en     = 1'b1;
            deck_ctl.rd_a_addr = r_n;
            deck_ctl.rd_b_addr = draw_j;
            n_j                = draw_j;
            n_swn              = r_n;
            n_n                = r_n - 1'b1;
        end

        // deck[n] <= old deck[j], then deck[j] <= old deck[n]
        if (r_wr1) begin
            deck_ctl.wr_en   = 1'b1;
            deck_ctl.wr_addr = r_swn;
            deck_ctl.wr_data = rd_b;
        end else if (r_wr2) begin
            deck_ctl.wr_en   = 1'b1;
            deck_ctl.wr_addr = r_j;
            deck_ctl.wr_data = rd_a;
        end else begin
            deck_ctl.wr_en   = fill_we;
            deck_ctl.wr_addr = r_fill;
            deck_ctl.wr_data = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_MUL_LL;
            r_first <= 1'b0;
            r_wr1   <= 1'b0;
            r_wr2   <= 1'b0;
            r_n     <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_first <= n_first;
            r_wr1   <= swap_rd;
            r_wr2   <= r_wr1;
            r_n     <= n_n;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_swn   <= n_swn;
        r_j     <= n_j;
        r_gen   <= n_gen;
        r_lo64  <= n_lo64;
        r_cross <= n_cross;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tlast  = (r_state == ST_EMIT) && (r_idx == LAST_CARD);
    assign m_axis_tdata  = {{PAD_W{1'b0}}, card_suit(rd_a), card_rank(rd_a), POS_W'(r_idx)};

    `LFYDS_ASSERT(a_in_out_excl, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "input ready while a card is offered")
    `LFYDS_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "no return to idle after last card")
    `LFYDS_ASSERT_IMP(a_draw_bound, i_clk, i_rst_n, r_state == ST_GEN && r_phase == PH_DRAW, r_n != '0, "draw issued for index zero")
    `LFYDS_ASSERT_IMP(a_swap_window, i_clk, i_rst_n, r_wr1 || r_wr2, r_state == ST_GEN || r_state == ST_TAIL, "swap write outside shuffle")

endmodule

// ===== src/lfyds_mul.sv =====
module lfyds_mul (
    input  logic                        i_clk,
    input  logic [lfyds_pkg::MUL_W-1:0] i_a,
    input  logic [lfyds_pkg::MUL_W-1:0] i_b,
    output logic [2*lfyds_pkg::MUL_W-1:0] o_prod
);
    import lfyds_pkg::*;

    logic [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {{MUL_W{1'b0}}, i_a} * {{MUL_W{1'b0}}, i_b};
    end

    assign o_prod = r_prod;

endmodule

// ===== src/lfyds_deck.sv =====
module lfyds_deck (
    input  logic                         i_clk,
    input  lfyds_pkg::t_deck_ctl         i_ctl,
    output logic [lfyds_pkg::CARD_W-1:0] o_rd_a,
    output logic [lfyds_pkg::CARD_W-1:0] o_rd_b
);
    import lfyds_pkg::*;

    logic [CARD_W-1:0] r_mem [DECK_SIZE];
    logic [CARD_W-1:0] r_rd_a;
    logic [CARD_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // Hold read data when not enabled so a pending swap keeps both cards.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_a <= r_mem[i_ctl.rd_a_addr];
            r_rd_b <= r_mem[i_ctl.rd_b_addr];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule
